### src/indexed_pair_list_unit_defines.svh
// assertion macros for the indexed pair list unit
`ifndef INDEXED_PAIR_LIST_UNIT_DEFINES_SVH
`define INDEXED_PAIR_LIST_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define IPL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define IPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ipl_pkg.sv
// package with codes, types and defaults of the indexed pair list unit
`timescale 1ns / 1ps

package ipl_pkg;

  localparam int unsigned DefaultDepth = 16;

  // request action codes
  localparam logic [2:0] ACT_CLEAR    = 3'd0;
  localparam logic [2:0] ACT_INSERT   = 3'd1;
  localparam logic [2:0] ACT_DELETE   = 3'd2;
  localparam logic [2:0] ACT_SET_TEMP = 3'd3;
  localparam logic [2:0] ACT_SET_TIME = 3'd4;
  localparam logic [2:0] ACT_READ     = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_SET_TEMP,
    CELL_SET_TIME
  } cell_op_e;

  typedef struct packed {
    logic [15:0] temp;
    logic [15:0] tval;
  } entry_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e    op;
    logic [3:0]  pos;
    logic [15:0] temp;
    logic [15:0] tval;
  } cell_cmd_t;

endpackage

### src/ipl_if.sv
// request and response channel interfaces of the indexed pair list unit
`timescale 1ns / 1ps

interface ipl_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [3:0]  position;
  logic [15:0] new_temp;
  logic [15:0] new_time;

  modport source (output valid, action, position, new_temp, new_time, input ready);
  modport sink (input valid, action, position, new_temp, new_time, output ready);
endinterface

interface ipl_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] read_temp;
  logic [15:0] read_time;
  logic [4:0]  count;

  modport source (output valid, status, read_temp, read_time, count, input ready);
  modport sink (input valid, status, read_temp, read_time, count, output ready);
endinterface

### src/ipl_cell.sv
// one list cell: holds an entry and takes it from a neighbor on shifts
`timescale 1ns / 1ps

module ipl_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic              clk_i,
  input  ipl_pkg::cell_cmd_t cmd_i,
  input  ipl_pkg::entry_t   left_i,
  input  ipl_pkg::entry_t   right_i,
  output ipl_pkg::entry_t   entry_o
);

  ipl_pkg::entry_t entry_q, entry_d;
  logic at_pos, above_pos;

  assign at_pos    = (Idx == int'(cmd_i.pos));
  assign above_pos = (Idx > int'(cmd_i.pos));

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      ipl_pkg::CELL_INSERT: begin
        if (above_pos) begin
          entry_d = left_i;
        end else if (at_pos) begin
          entry_d.temp = cmd_i.temp;
          entry_d.tval = cmd_i.tval;
        end
      end
      ipl_pkg::CELL_DELETE: begin
        if (above_pos || at_pos) begin
          entry_d = right_i;
        end
      end
      ipl_pkg::CELL_SET_TEMP: begin
        if (at_pos) begin
          entry_d.temp = cmd_i.temp;
        end
      end
      ipl_pkg::CELL_SET_TIME: begin
        if (at_pos) begin
          entry_d.tval = cmd_i.tval;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### src/indexed_pair_list_unit.sv
// indexed pair list unit: ordered list of temperature and time pairs
//
// usage
// - req_i carries one request item: action, position, new_temp, new_time
// - rsp_o returns one result item per request: status, read_temp,
//   read_time and the count after the action, in request order
// - both channels move an item on a clock edge with valid and ready high
// - a request is applied to the cell chain in the cycle it is accepted;
//   its result passes the pending stage, then the output register reads
//   the addressed cell and the result turns valid there, to be taken
//   when the receiver is ready
// - throughput is one item per cycle while the receiver takes results:
//   every insert or delete shifts the whole chain of cells in a single step
// - when the receiver stalls, one result waits in the output register and
//   one more in the pending stage; ready on req_i drops only when both
//   are full
// - reset clears the count and both stages; cell contents are not reset
//   and cannot be read until written again
// - clear only zeroes the count, the words stay in the cells
// - positions beyond 15 are not addressable, the count is reported in
//   five bits
`timescale 1ns / 1ps

`include "indexed_pair_list_unit_defines.svh"

module indexed_pair_list_unit #(
  parameter int unsigned Depth = ipl_pkg::DefaultDepth
) (
  input logic       clk_i,
  input logic       rst_ni,
  ipl_req_if.sink   req_i,
  ipl_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CmpW = CntW + 4;

  // list count
  logic [CntW-1:0] count_q, count_d;

  // pending stage: request applied, waiting for the cell read
  logic            pend_q, pend_d;
  logic [3:0]      pos_q;
  logic [1:0]      pend_status_q;
  logic            rd_ok_q;

  // output register
  logic            rsp_valid_q, rsp_valid_d;
  logic [1:0]      status_q;
  logic [15:0]     read_temp_q;
  logic [15:0]     read_time_q;
  logic [CntW-1:0] rsp_count_q;

  logic            advance, accept;
  logic [CmpW-1:0] pos_w, cnt_w, cnt_next_w;
  logic            in_range, is_full, ins_ok;
  logic [1:0]      status_d;

  ipl_pkg::cell_cmd_t cmd;
  ipl_pkg::entry_t    cells [Depth];

  // handshake
  assign advance     = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = !pend_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  // range and fullness checks on the current count
  assign pos_w    = {{CntW{1'b0}}, req_i.position};
  assign cnt_w    = {4'b0000, count_q};
  assign in_range = (pos_w < cnt_w);
  assign is_full  = (count_q == CntW'(Depth));
  assign ins_ok   = !is_full && (pos_w <= cnt_w);

  // decode the action into status, next count and cell command
  always_comb begin
    status_d = ipl_pkg::ST_OK;
    count_d  = count_q;
    cmd.op   = ipl_pkg::CELL_HOLD;
    cmd.pos  = req_i.position;
    cmd.temp = req_i.new_temp;
    cmd.tval = req_i.new_time;
    unique case (req_i.action)
      ipl_pkg::ACT_CLEAR: begin
        count_d = '0;
      end
      ipl_pkg::ACT_INSERT: begin
        if (is_full) begin
          status_d = ipl_pkg::ST_FULL;
        end else if (!ins_ok) begin
          status_d = ipl_pkg::ST_RANGE;
        end else begin
          count_d = count_q + CntW'(1);
          cmd.op  = ipl_pkg::CELL_INSERT;
        end
      end
      ipl_pkg::ACT_DELETE: begin
        if (!in_range) begin
          status_d = ipl_pkg::ST_RANGE;
        end else begin
          count_d = count_q - CntW'(1);
          cmd.op  = ipl_pkg::CELL_DELETE;
        end
      end
      ipl_pkg::ACT_SET_TEMP: begin
        if (!in_range) begin
          status_d = ipl_pkg::ST_RANGE;
        end else begin
          cmd.op = ipl_pkg::CELL_SET_TEMP;
        end
      end
      ipl_pkg::ACT_SET_TIME: begin
        if (!in_range) begin
          status_d = ipl_pkg::ST_RANGE;
        end else begin
          cmd.op = ipl_pkg::CELL_SET_TIME;
        end
      end
      ipl_pkg::ACT_READ: begin
        if (!in_range) begin
          status_d = ipl_pkg::ST_RANGE;
        end
      end
      default: begin
        // reserved actions change nothing
        status_d = ipl_pkg::ST_RANGE;
      end
    endcase
    if (!accept) begin
      cmd.op  = ipl_pkg::CELL_HOLD;
      count_d = count_q;
    end
  end

  assign cnt_next_w = {4'b0000, count_d};

  // chain of cells, each fed by both neighbors; the ends feed themselves
  for (genvar k = 0; k < Depth; k++) begin : g_cell
    ipl_pkg::entry_t left, right;
    if (k == 0) begin : g_first
      assign left = cells[k];
    end else begin : g_left
      assign left = cells[k-1];
    end
    if (k == Depth - 1) begin : g_last
      assign right = cells[k];
    end else begin : g_right
      assign right = cells[k+1];
    end
    ipl_cell #(
      .Idx(k)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left),
      .right_i(right),
      .entry_o(cells[k])
    );
  end

  // read index into the chain, valid only when the read is in range
  logic [IdxW+3:0] pos_wide;
  logic [IdxW-1:0] rd_idx;
  assign pos_wide = {{IdxW{1'b0}}, pos_q};
  assign rd_idx   = pos_wide[IdxW-1:0];

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b1;
    end else if (advance) begin
      pend_d = 1'b0;
    end
    rsp_valid_d = rsp_valid_q;
    if (advance) begin
      rsp_valid_d = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // pending stage payload
  logic [CntW-1:0] pend_count_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q         <= req_i.position;
      pend_status_q <= status_d;
      rd_ok_q       <= (pos_w < cnt_next_w);
      pend_count_q  <= count_d;
    end
  end

  // output register reads the addressed cell after the action
  always_ff @(posedge clk_i) begin
    if (advance && pend_q) begin
      status_q    <= pend_status_q;
      rsp_count_q <= pend_count_q;
      read_temp_q <= rd_ok_q ? cells[rd_idx].temp : 16'h0000;
      read_time_q <= rd_ok_q ? cells[rd_idx].tval : 16'h0000;
    end
  end

  logic [CntW+4:0] rsp_count_w;
  assign rsp_count_w = {5'b00000, rsp_count_q};

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.read_temp = read_temp_q;
  assign rsp_o.read_time = read_time_q;
  assign rsp_o.count     = rsp_count_w[4:0];

  // checks
  `IPL_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(Depth),
    "list count above depth")
  `IPL_ASSERT_NEXT(a_clear_count, clk_i, rst_ni,
    accept && req_i.action == ipl_pkg::ACT_CLEAR, count_q == '0,
    "clear left a nonzero count")
  `IPL_ASSERT_NEXT(a_insert_count, clk_i, rst_ni,
    accept && req_i.action == ipl_pkg::ACT_INSERT && ins_ok,
    count_q == $past(count_q) + CntW'(1), "insert did not grow the count")
  `IPL_ASSERT_NOW(a_full_status, clk_i, rst_ni,
    pend_q && pend_status_q == ipl_pkg::ST_FULL, count_q == CntW'(Depth),
    "full status with room in the list")

endmodule
